>>> design/assert_macros.svh
// Assertion macros for the voice channel allocator checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/pvca_pkg.sv
// Shared types and constants for the voice channel allocator.
// No dependencies.
package pvca_pkg;
	localparam int CHANNELS = 8;
	localparam int CH_W     = 3;
	localparam int CNT_W    = 4;
	localparam int ORG_W    = 16;
	localparam int RANK_W   = 8;
	localparam int MASK_W   = 8;

	localparam logic [CNT_W-1:0] ACTIVE_RESET = 4'd8;

	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_STOP    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_FINISH = 1'b1
	} state_t;

	typedef struct packed {
		logic accept;
		logic finish;
	} cmd_t;
endpackage

>>> design/pvca_ctrl.sv
// Handshake controller for the voice channel allocator.
// Depends on pvca_pkg.
module pvca_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output pvca_pkg::cmd_t  cmd
);
	pvca_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_hold;

	assign out_hold = out_valid_q && out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pvca_pkg::ST_IDLE: begin
				if (in_valid) state_d = pvca_pkg::ST_FINISH;
			end
			pvca_pkg::ST_FINISH: begin
				if (!out_hold) state_d = pvca_pkg::ST_IDLE;
			end
			default: state_d = pvca_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.accept = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			pvca_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			pvca_pkg::ST_FINISH: begin
				cmd.finish = !out_hold;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pvca_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

>>> design/pvca_datapath.sv
// Channel table, first-match searches and result register.
// Depends on pvca_pkg.
module pvca_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pvca_pkg::cmd_t                cmd,
	input  logic [1:0]                    opcode,
	input  logic [pvca_pkg::ORG_W-1:0]    origin,
	input  logic [pvca_pkg::RANK_W-1:0]   rank,
	input  logic [pvca_pkg::CH_W-1:0]     channel,
	input  logic                          cfg_we,
	input  logic [pvca_pkg::CNT_W-1:0]    cfg_data,
	output logic                          granted,
	output logic                          refused,
	output logic [pvca_pkg::CH_W-1:0]     grant_channel,
	output logic [pvca_pkg::MASK_W-1:0]   stop_mask
);
	logic [pvca_pkg::CNT_W-1:0]    active_q;
	logic [pvca_pkg::CNT_W-1:0]    live;
	logic [pvca_pkg::CHANNELS-1:0] live_en;
	logic [pvca_pkg::CHANNELS-1:0] busy_q;
	logic [pvca_pkg::ORG_W-1:0]    org_tab_q  [pvca_pkg::CHANNELS];
	logic [pvca_pkg::RANK_W-1:0]   rank_tab_q [pvca_pkg::CHANNELS];

	pvca_pkg::op_t                 op_q;
	logic [pvca_pkg::ORG_W-1:0]    org_q;
	logic [pvca_pkg::RANK_W-1:0]   rk_q;
	logic [pvca_pkg::MASK_W-1:0]   mask_q;

	logic [pvca_pkg::CHANNELS-1:0] free1;
	logic [pvca_pkg::CHANNELS-1:0] hit1;
	logic [pvca_pkg::CHANNELS-1:0] hit2;
	logic [pvca_pkg::CHANNELS-1:0] hit3;
	logic [pvca_pkg::CH_W-1:0]     c2, c3, sel;
	logic                          found2, found3, found, is_start;
	logic [pvca_pkg::CHANNELS-1:0] stop2;
	pvca_pkg::op_t                 op_in;

	assign op_in = pvca_pkg::op_t'(opcode);
	assign live  = (active_q > pvca_pkg::CNT_W'(pvca_pkg::CHANNELS)) ?
		pvca_pkg::CNT_W'(pvca_pkg::CHANNELS) : active_q;

	always_comb begin
		for (int c = 0; c < pvca_pkg::CHANNELS; c++) begin
			live_en[c] = pvca_pkg::CNT_W'(c) < live;
			hit1[c] = live_en[c] && busy_q[c] && (org_tab_q[c] == origin);
			hit2[c] = live_en[c] && (!busy_q[c] ||
				((org_q != '0) && (org_tab_q[c] == org_q)));
			hit3[c] = live_en[c] && (rank_tab_q[c] >= rk_q);
		end
	end

	// stop, release and clear on the accepted beat
	always_comb begin
		free1 = '0;
		case (op_in)
			pvca_pkg::OP_START, pvca_pkg::OP_STOP: begin
				for (int c = pvca_pkg::CHANNELS - 1; c >= 0; c--) begin
					if (hit1[c]) begin
						free1 = '0;
						free1[c] = 1'b1;
					end
				end
			end
			pvca_pkg::OP_RELEASE: begin
				free1[channel] = live_en[channel] && busy_q[channel];
			end
			pvca_pkg::OP_CLEAR: begin
				free1 = live_en & busy_q;
			end
			default: free1 = '0;
		endcase
	end

	// allocate on the finish cycle
	always_comb begin
		c2 = '0;
		c3 = '0;
		for (int c = pvca_pkg::CHANNELS - 1; c >= 0; c--) begin
			if (hit2[c]) c2 = pvca_pkg::CH_W'(c);
			if (hit3[c]) c3 = pvca_pkg::CH_W'(c);
		end
		found2   = |hit2;
		found3   = |hit3;
		found    = found2 || found3;
		is_start = (op_q == pvca_pkg::OP_START);
		sel      = found2 ? c2 : c3;
		stop2    = '0;
		if (is_start && found) stop2[sel] = busy_q[sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= pvca_pkg::ACTIVE_RESET;
			busy_q   <= '0;
			for (int c = 0; c < pvca_pkg::CHANNELS; c++) begin
				org_tab_q[c]  <= '0;
				rank_tab_q[c] <= '0;
			end
		end else begin
			if (cfg_we) active_q <= cfg_data;
			if (cmd.accept) begin
				busy_q <= busy_q & ~free1;
				for (int c = 0; c < pvca_pkg::CHANNELS; c++) begin
					if (free1[c]) org_tab_q[c] <= '0;
				end
			end else if (cmd.finish && is_start && found) begin
				busy_q[sel]     <= 1'b1;
				org_tab_q[sel]  <= org_q;
				rank_tab_q[sel] <= rk_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op_in;
			org_q  <= origin;
			rk_q   <= rank;
			mask_q <= pvca_pkg::MASK_W'(free1);
		end
		if (cmd.finish) begin
			granted       <= is_start && found;
			refused       <= is_start && !found;
			grant_channel <= (is_start && found) ? sel : '0;
			stop_mask     <= mask_q | pvca_pkg::MASK_W'(stop2);
		end
	end
endmodule

>>> design/priority_voice_channel_allocator_top.sv
// Priority voice channel allocator, top level.
// The input beat is registered on accept; the result beat is registered in the finish
// state and shown on out_valid. in_stall holds off a new beat until then. The table is
// updated by the stop/release/clear pass on accept and by the allocation pass at finish.
// Reset: arst_n clears all channels to free and sets active_channels to 8.
// Depends on pvca_pkg, pvca_ctrl and pvca_datapath.
module priority_voice_channel_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [pvca_pkg::ORG_W-1:0]    origin,
	input  logic [pvca_pkg::RANK_W-1:0]   rank,
	input  logic [pvca_pkg::CH_W-1:0]     channel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          granted,
	output logic                          refused,
	output logic [pvca_pkg::CH_W-1:0]     grant_channel,
	output logic [pvca_pkg::MASK_W-1:0]   stop_mask,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pvca_pkg::CNT_W-1:0]    cfg_data
);
	pvca_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	pvca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	pvca_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (opcode),
		.origin        (origin),
		.rank          (rank),
		.channel       (channel),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.granted       (granted),
		.refused       (refused),
		.grant_channel (grant_channel),
		.stop_mask     (stop_mask)
	);
endmodule

>>> design/pvca_checker.sv
// Port-level checker for the voice channel allocator, bound to the top level.
// Depends on assert_macros.svh and pvca_pkg.
`include "assert_macros.svh"

module pvca_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          granted,
	input logic                          refused,
	input logic [pvca_pkg::CH_W-1:0]     grant_channel,
	input logic [pvca_pkg::MASK_W-1:0]   stop_mask
);
	`CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(granted) && $stable(refused) && $stable(grant_channel) && $stable(stop_mask), "result beat changed while stalled")
	`CHK_IMPLY(a_excl, out_valid, !(granted && refused), "granted and refused together")
	`CHK_IMPLY(a_gch_zero, out_valid && !granted, grant_channel == '0, "grant channel set without grant")
	`CHK_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second beat taken while item in work")
endmodule

bind priority_voice_channel_allocator_top pvca_checker u_pvca_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.granted       (granted),
	.refused       (refused),
	.grant_channel (grant_channel),
	.stop_mask     (stop_mask)
);
